// File: design/sdspi_pkg.sv
package sdspi_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int PREINIT_BYTES = 10;
  localparam int CMD_TAIL_BYTES = 5;
  localparam int RESP_TAIL_BYTES = 3;
  localparam int CNT_MAX = (BLOCK_BYTES > PREINIT_BYTES + 1) ? BLOCK_BYTES : PREINIT_BYTES + 1;
  localparam int CNT_W = $clog2(CNT_MAX);

  localparam logic [7:0] POLL_LIMIT_RESET = 8'd20;
  localparam logic [7:0] CMD_START_BITS = 8'h40;
  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam logic [7:0] TOKEN_HI_MASK = 8'hF0;
  localparam logic [4:0] DRESP_ACCEPTED = 5'h05;
  localparam logic [4:0] DRESP_CRC_ERR = 5'h0B;

  typedef enum logic [1:0] {
    FN_START   = 2'd0,
    FN_XFER    = 2'd1,
    FN_PREINIT = 2'd2,
    FN_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DP_NONE  = 2'd0,
    DP_RESP4 = 2'd1,
    DP_READ  = 2'd2,
    DP_WRITE = 2'd3
  } data_phase_t;

  typedef enum logic [1:0] {
    RK_R1   = 2'd0,
    RK_RESP = 2'd1,
    RK_DATA = 2'd2,
    RK_CRC  = 2'd3
  } rx_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_R1     = 3'd1,
    ST_READ_TOK  = 3'd2,
    ST_WRITE_CRC = 3'd3,
    ST_WRITE_ERR = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_PREINIT  = 4'd1,
    PH_COMMAND  = 4'd2,
    PH_FLAGS    = 4'd3,
    PH_RESPONSE = 4'd4,
    PH_RTOKEN   = 4'd5,
    PH_RDATA    = 4'd6,
    PH_RCRC     = 4'd7,
    PH_WDATA    = 4'd8,
    PH_WCRC     = 4'd9,
    PH_WRESP    = 4'd10,
    PH_BUSY     = 4'd11,
    PH_DONE     = 4'd12
  } phase_t;

  typedef struct packed {
    func_t       func;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [7:0]  cmd_crc;
    data_phase_t data_phase;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_byte;
  } req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       wr_taken;
    logic       rx_valid;
    rx_kind_t   rx_kind;
    logic [7:0] rx_data;
    logic       done_res;
    status_t    status;
    logic [3:0] error_token;
  } res_t;

endpackage

// File: design/sdspi_in_stage.sv
module sdspi_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sdspi_pkg::req_t in_req,
  input  logic          advance,
  output logic          req_valid,
  output sdspi_pkg::req_t req
);

  assign in_ready = !rst && (!req_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req <= '0;
    end else if (in_valid && in_ready) begin
      req <= in_req;
    end
  end

endmodule

// File: design/sdspi_engine.sv
module sdspi_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  sdspi_pkg::req_t req,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_data,
  output sdspi_pkg::res_t res
);

  sdspi_pkg::phase_t               phase, phase_next;
  logic [sdspi_pkg::CNT_W-1:0]     byte_count, byte_count_next;
  logic [7:0]                      poll_count, poll_count_next;
  sdspi_pkg::data_phase_t          mode, mode_next;
  logic [39:0]                     command_shift, command_shift_next;
  logic [1:0]                      crc_left, crc_left_next;
  logic [7:0]                      poll_limit;

  logic [7:0] rx;
  logic       rx_is_r1;
  logic       cnt_zero;
  logic [1:0] crc_dec;

  assign rx       = req.rx_byte;
  assign rx_is_r1 = !rx[7];
  assign cnt_zero = (byte_count == '0);
  assign crc_dec  = crc_left - 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= sdspi_pkg::POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      poll_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sdspi_pkg::PH_IDLE;
      byte_count    <= '0;
      poll_count    <= '0;
      mode          <= sdspi_pkg::DP_NONE;
      command_shift <= '0;
      crc_left      <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      poll_count    <= poll_count_next;
      mode          <= mode_next;
      command_shift <= command_shift_next;
      crc_left      <= crc_left_next;
    end
  end

  // next state
  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    poll_count_next    = poll_count;
    mode_next          = mode;
    command_shift_next = command_shift;
    crc_left_next      = crc_left;
    unique case (req.func)
      sdspi_pkg::FN_START: begin
        command_shift_next = {req.cmd_arg, req.cmd_crc};
        byte_count_next    = sdspi_pkg::CNT_W'(sdspi_pkg::CMD_TAIL_BYTES);
        poll_count_next    = poll_limit;
        mode_next          = req.data_phase;
        crc_left_next      = 2'd0;
        phase_next         = sdspi_pkg::PH_COMMAND;
      end
      sdspi_pkg::FN_PREINIT: begin
        byte_count_next = sdspi_pkg::CNT_W'(sdspi_pkg::PREINIT_BYTES);
        phase_next      = sdspi_pkg::PH_PREINIT;
      end
      sdspi_pkg::FN_XFER: begin
        unique case (phase)
          sdspi_pkg::PH_IDLE: begin
          end
          sdspi_pkg::PH_PREINIT: begin
            if (!cnt_zero) begin
              byte_count_next = byte_count - 1'b1;
            end else begin
              phase_next = sdspi_pkg::PH_DONE;
            end
          end
          sdspi_pkg::PH_COMMAND: begin
            if (!cnt_zero) begin
              command_shift_next = {command_shift[31:0], 8'h00};
              byte_count_next    = byte_count - 1'b1;
            end else begin
              phase_next = sdspi_pkg::PH_FLAGS;
            end
          end
          sdspi_pkg::PH_FLAGS: begin
            if (rx_is_r1) begin
              unique case (mode)
                sdspi_pkg::DP_WRITE: begin
                  byte_count_next = sdspi_pkg::CNT_W'(sdspi_pkg::BLOCK_BYTES - 1);
                  phase_next      = sdspi_pkg::PH_WDATA;
                end
                sdspi_pkg::DP_RESP4: begin
                  byte_count_next = sdspi_pkg::CNT_W'(sdspi_pkg::RESP_TAIL_BYTES);
                  phase_next      = sdspi_pkg::PH_RESPONSE;
                end
                sdspi_pkg::DP_READ: begin
                  byte_count_next = sdspi_pkg::CNT_W'(sdspi_pkg::BLOCK_BYTES - 1);
                  phase_next      = sdspi_pkg::PH_RTOKEN;
                end
                default: begin
                  phase_next = sdspi_pkg::PH_DONE;
                end
              endcase
            end else if (poll_count == 8'd0) begin
              phase_next = sdspi_pkg::PH_IDLE;
            end else begin
              poll_count_next = poll_count - 8'd1;
            end
          end
          sdspi_pkg::PH_RESPONSE: begin
            if (cnt_zero) begin
              phase_next = sdspi_pkg::PH_DONE;
            end else begin
              byte_count_next = byte_count - 1'b1;
            end
          end
          sdspi_pkg::PH_RTOKEN: begin
            if ((rx & sdspi_pkg::TOKEN_HI_MASK) == 8'h00) begin
              phase_next = sdspi_pkg::PH_IDLE;
            end else if (rx == sdspi_pkg::TOKEN_START) begin
              phase_next = sdspi_pkg::PH_RDATA;
            end
          end
          sdspi_pkg::PH_RDATA: begin
            if (cnt_zero) begin
              crc_left_next = 2'd2;
              phase_next    = sdspi_pkg::PH_RCRC;
            end else begin
              byte_count_next = byte_count - 1'b1;
            end
          end
          sdspi_pkg::PH_RCRC: begin
            crc_left_next = crc_dec;
            if (crc_dec == 2'd0) begin
              phase_next = sdspi_pkg::PH_DONE;
            end
          end
          sdspi_pkg::PH_WDATA: begin
            if (cnt_zero) begin
              crc_left_next = 2'd2;
              phase_next    = sdspi_pkg::PH_WCRC;
            end else begin
              byte_count_next = byte_count - 1'b1;
            end
          end
          sdspi_pkg::PH_WCRC: begin
            crc_left_next = crc_dec;
            if (crc_dec == 2'd0) begin
              phase_next = sdspi_pkg::PH_WRESP;
            end
          end
          sdspi_pkg::PH_WRESP: begin
            if (rx == sdspi_pkg::FILL_BYTE) begin
              phase_next = phase;
            end else if (rx[4:0] == sdspi_pkg::DRESP_ACCEPTED) begin
              phase_next = sdspi_pkg::PH_BUSY;
            end else begin
              phase_next = sdspi_pkg::PH_IDLE;
            end
          end
          sdspi_pkg::PH_BUSY: begin
            if (rx != 8'h00) begin
              phase_next = sdspi_pkg::PH_DONE;
            end
          end
          default: begin
            phase_next = sdspi_pkg::PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // result
  always_comb begin
    res = '0;
    unique case (req.func)
      sdspi_pkg::FN_START: begin
        res.tx_valid    = 1'b1;
        res.tx_byte     = sdspi_pkg::CMD_START_BITS | {2'b00, req.cmd_index};
        res.chip_select = 1'b1;
      end
      sdspi_pkg::FN_PREINIT: begin
        res.tx_valid = 1'b1;
        res.tx_byte  = sdspi_pkg::FILL_BYTE;
      end
      sdspi_pkg::FN_XFER: begin
        if (phase != sdspi_pkg::PH_IDLE) begin
          res.chip_select = (phase != sdspi_pkg::PH_PREINIT);
          res.tx_valid    = 1'b1;
          res.tx_byte     = sdspi_pkg::FILL_BYTE;
          unique case (phase)
            sdspi_pkg::PH_COMMAND: begin
              if (!cnt_zero) begin
                res.tx_byte = command_shift[39:32];
              end
            end
            sdspi_pkg::PH_FLAGS: begin
              if (rx_is_r1) begin
                res.rx_valid = 1'b1;
                res.rx_kind  = sdspi_pkg::RK_R1;
                res.rx_data  = rx;
                if (mode == sdspi_pkg::DP_WRITE) begin
                  res.tx_byte = sdspi_pkg::TOKEN_START;
                end
              end else if (poll_count == 8'd0) begin
                res.tx_valid    = 1'b0;
                res.tx_byte     = 8'h00;
                res.chip_select = 1'b0;
                res.done_res    = 1'b1;
                res.status      = sdspi_pkg::ST_NO_R1;
              end
            end
            sdspi_pkg::PH_RESPONSE: begin
              res.rx_valid = 1'b1;
              res.rx_kind  = sdspi_pkg::RK_RESP;
              res.rx_data  = rx;
            end
            sdspi_pkg::PH_RTOKEN: begin
              if ((rx & sdspi_pkg::TOKEN_HI_MASK) == 8'h00) begin
                res.tx_valid    = 1'b0;
                res.tx_byte     = 8'h00;
                res.chip_select = 1'b0;
                res.done_res    = 1'b1;
                res.status      = sdspi_pkg::ST_READ_TOK;
                res.error_token = rx[3:0];
              end
            end
            sdspi_pkg::PH_RDATA: begin
              res.rx_valid = 1'b1;
              res.rx_kind  = sdspi_pkg::RK_DATA;
              res.rx_data  = rx;
            end
            sdspi_pkg::PH_RCRC: begin
              res.rx_valid = 1'b1;
              res.rx_kind  = sdspi_pkg::RK_CRC;
              res.rx_data  = rx;
            end
            sdspi_pkg::PH_WDATA: begin
              res.tx_byte  = req.wr_byte;
              res.wr_taken = 1'b1;
            end
            sdspi_pkg::PH_WRESP: begin
              // unknown response codes count as write errors
              if (rx != sdspi_pkg::FILL_BYTE && rx[4:0] != sdspi_pkg::DRESP_ACCEPTED) begin
                res.tx_valid    = 1'b0;
                res.tx_byte     = 8'h00;
                res.chip_select = 1'b0;
                res.done_res    = 1'b1;
                res.status      = (rx[4:0] == sdspi_pkg::DRESP_CRC_ERR) ?
                                  sdspi_pkg::ST_WRITE_CRC : sdspi_pkg::ST_WRITE_ERR;
              end
            end
            sdspi_pkg::PH_PREINIT, sdspi_pkg::PH_WCRC, sdspi_pkg::PH_BUSY: begin
            end
            default: begin
              res.tx_valid    = 1'b0;
              res.tx_byte     = 8'h00;
              res.chip_select = 1'b0;
              res.done_res    = 1'b1;
              res.status      = sdspi_pkg::ST_OK;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res.done_res |=> phase == sdspi_pkg::PH_IDLE)
    else $error("transaction end did not return to idle");

  a_wr_only_in_wdata: assert property (@(posedge clk) disable iff (rst)
    fire && res.wr_taken |-> phase == sdspi_pkg::PH_WDATA && res.chip_select)
    else $error("write byte taken outside data phase");

  a_start_loads_cmd: assert property (@(posedge clk) disable iff (rst)
    fire && req.func == sdspi_pkg::FN_START |=>
      phase == sdspi_pkg::PH_COMMAND && poll_count == $past(poll_limit))
    else $error("command start did not load command state");

  a_status_needs_done: assert property (@(posedge clk) disable iff (rst)
    fire && res.status != sdspi_pkg::ST_OK |-> res.done_res && !res.tx_valid)
    else $error("error status without transaction end");

endmodule

// File: design/sdspi_out_stage.sv
module sdspi_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  sdspi_pkg::res_t res_in,
  output logic            out_valid,
  input  logic            out_ready,
  output sdspi_pkg::res_t res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_in;
    end
  end

endmodule

// File: design/sd_spi_transaction_engine.sv
// an accepted request waits in the request register; its result is captured in the
// result register once that register is free or being drained
// throughput: one request per cycle while the result register is free or drained;
// each byte exchange is one phase state machine step between the two registers
// reset: phase idle, counters and command shift cleared, response poll limit 20,
// both pipeline registers empty
module sd_spi_transaction_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [5:0]  cmd_index,
  input  logic [31:0] cmd_arg,
  input  logic [7:0]  cmd_crc,
  input  logic [1:0]  data_phase,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  wr_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        chip_select,
  output logic        wr_taken,
  output logic        rx_valid,
  output logic [1:0]  rx_kind,
  output logic [7:0]  rx_data,
  output logic        done_res,
  output logic [2:0]  status,
  output logic [3:0]  error_token,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  sdspi_pkg::req_t in_req;
  sdspi_pkg::req_t req;
  sdspi_pkg::res_t step_res;
  sdspi_pkg::res_t res;
  logic            req_valid;
  logic            advance;

  assign in_req.func       = sdspi_pkg::func_t'(func);
  assign in_req.cmd_index  = cmd_index;
  assign in_req.cmd_arg    = cmd_arg;
  assign in_req.cmd_crc    = cmd_crc;
  assign in_req.data_phase = sdspi_pkg::data_phase_t'(data_phase);
  assign in_req.rx_byte    = rx_byte;
  assign in_req.wr_byte    = wr_byte;

  assign advance   = req_valid && (!out_valid || out_ready);
  assign cfg_ready = !rst;

  sdspi_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  sdspi_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .req      (req),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .res      (step_res)
  );

  sdspi_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res_in    (step_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign tx_valid    = res.tx_valid;
  assign tx_byte     = res.tx_byte;
  assign chip_select = res.chip_select;
  assign wr_taken    = res.wr_taken;
  assign rx_valid    = res.rx_valid;
  assign rx_kind     = res.rx_kind;
  assign rx_data     = res.rx_data;
  assign done_res    = res.done_res;
  assign status      = res.status;
  assign error_token = res.error_token;

endmodule
